>>> rtl/core/siad_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// siad_pkg: shared definitions for the signed integer to ASCII converter
// Character codes, the default value width and the digit to ASCII mapping.
// ----------------------------------------------------------------------------
package siad_pkg;

  localparam int VALUE_BITS_DEFAULT = 32;

  // Binary bits consumed by the conversion unit in one cycle.
  localparam int STEP_BITS = 4;

  localparam logic [6:0] CH_MINUS   = 7'h2D;
  localparam logic [6:0] CH_ZERO    = 7'h30;
  localparam logic [6:0] CH_UPPER_A = 7'h41;

  localparam logic [3:0] DIGIT_TEN = 4'd10;

  // Maps one digit (0..15) to '0'..'9' or 'A'..'F'.
  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] ch;
    if (d < DIGIT_TEN) begin
      ch = CH_ZERO + {3'b000, d};
    end else begin
      ch = CH_UPPER_A + {3'b000, d - DIGIT_TEN};
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/siad_dabble.sv
`default_nettype none
// ----------------------------------------------------------------------------
// siad_dabble: binary to BCD conversion step
// Applies several shift-and-add-3 steps to a packed BCD and binary word.
// ----------------------------------------------------------------------------
module siad_dabble #(
  parameter int MAG_W   = 32,
  parameter int DIG_NUM = 10
) (
  input  wire logic [DIG_NUM*4-1:0] dig_i,
  input  wire logic [MAG_W-1:0]     bin_i,
  output logic      [DIG_NUM*4-1:0] dig_o,
  output logic      [MAG_W-1:0]     bin_o
);

  localparam int AccW = DIG_NUM * 4 + MAG_W;

  logic [AccW-1:0] acc;

  // Each step corrects every BCD digit that would overflow on doubling,
  // then shifts the whole word left by one bit.
  always_comb begin
    acc = {dig_i, bin_i};
    for (int s = 0; s < siad_pkg::STEP_BITS; s++) begin
      for (int d = 0; d < DIG_NUM; d++) begin
        if (acc[MAG_W + 4*d +: 4] >= 4'd5) begin
          acc[MAG_W + 4*d +: 4] = acc[MAG_W + 4*d +: 4] + 4'd3;
        end
      end
      acc = {acc[AccW-2:0], 1'b0};
    end
  end

  assign dig_o = acc[AccW-1:MAG_W];
  assign bin_o = acc[MAG_W-1:0];

endmodule
`default_nettype wire

>>> rtl/core/signed_integer_to_ascii_digits.sv
`default_nettype none
// ----------------------------------------------------------------------------
// signed_integer_to_ascii_digits: signed integer to ASCII text converter
// Renders a two's complement value as decimal or uppercase hex characters.
// ----------------------------------------------------------------------------
// Usage:
// An input beat carries the value in in_tdata and the radix select in
// in_tuser (0 decimal, 1 hexadecimal). The block answers with one output
// beat per character, most significant first, with no leading zeros. A
// negative value starts with '-' followed by its magnitude; the most
// negative value shows its full magnitude. out_tlast marks the final
// character of each value.
// Timing: decimal values pass through a binary to BCD unit that consumes
// four bits per cycle; hex values skip it. The digit register holds ten
// digit slots at 32 bits: leading zero slots are dropped one per cycle,
// the scan then ends, then one character leaves per cycle. So every value
// of one radix and sign takes equally long from one taken beat to the
// next, while the receiver keeps up.
// in_tready is high only while no value is being converted. The last
// character sits in the output register, so the next beat is taken while
// it waits. When the receiver stalls, the sequencer holds its place and
// the current character stays on out_tdata. Reset clears the sequencer and
// drops out_tvalid.
// ----------------------------------------------------------------------------
module signed_integer_to_ascii_digits #(
  parameter int VALUE_BITS = siad_pkg::VALUE_BITS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input channel.
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [((VALUE_BITS+7)/8)*8-1:0]   in_tdata,   // [VALUE_BITS-1:0] value
  input  wire logic                              in_tuser,   // [0] mode
  // Output channel.
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [7:0]                        out_tdata,  // [6:0] ascii_char
  output logic                                   out_tlast
);

  // Storage for the digits: enough for the decimal form of 2^(VALUE_BITS-1)
  // and for the hex form of a full value.
  localparam int MagW   = ((VALUE_BITS + 3) / 4) * 4;
  localparam int DecDig = ((VALUE_BITS - 1) * 31) / 100 + 1;
  localparam int HexDig = MagW / 4;
  localparam int DigNum = (DecDig > HexDig) ? DecDig : HexDig;
  localparam int DigW   = DigNum * 4;
  localparam int Steps  = MagW / siad_pkg::STEP_BITS;
  localparam int StepW  = $clog2(Steps + 1);
  localparam int CntW   = $clog2(DigNum + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SKIP = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [DigW-1:0]       dig_r, dig_nxt;
  logic [MagW-1:0]       bin_r, bin_nxt;
  logic                  neg_r, neg_nxt;
  logic [StepW-1:0]      step_r, step_nxt;
  logic [CntW-1:0]       cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [6:0]            out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;
  logic [DigW-1:0]       dab_dig;
  logic [MagW-1:0]       dab_bin;
  logic [3:0]            top_dig;
  logic                  out_free;

  // The negation of the most negative value wraps to itself, which read as
  // unsigned is exactly its magnitude.
  assign raw = in_tdata[VALUE_BITS-1:0];
  assign mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

  assign top_dig  = dig_r[DigW-1 -: 4];
  assign out_free = !out_valid_r || out_tready;

  siad_dabble #(
    .MAG_W   (MagW),
    .DIG_NUM (DigNum)
  ) u_dabble (
    .dig_i (dig_r),
    .bin_i (bin_r),
    .dig_o (dab_dig),
    .bin_o (dab_bin)
  );

  always_comb begin
    state_nxt     = state_r;
    dig_nxt       = dig_r;
    bin_nxt       = bin_r;
    neg_nxt       = neg_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          neg_nxt = raw[VALUE_BITS-1];
          cnt_nxt = CntW'(DigNum);
          if (in_tuser) begin
            // Hex digits are the nibbles of the magnitude.
            dig_nxt   = DigW'(mag);
            bin_nxt   = '0;
            state_nxt = ST_SKIP;
          end else begin
            dig_nxt   = '0;
            bin_nxt   = MagW'(mag);
            step_nxt  = StepW'(Steps);
            state_nxt = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        dig_nxt  = dab_dig;
        bin_nxt  = dab_bin;
        step_nxt = step_r - 1'b1;
        if (step_r == StepW'(1)) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop leading zeros, but always keep the final digit.
        if (top_dig == 4'd0 && cnt_r > CntW'(1)) begin
          dig_nxt = {dig_r[DigW-5:0], 4'd0};
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = siad_pkg::CH_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = siad_pkg::digit_char(top_dig);
          out_last_nxt  = (cnt_r == CntW'(1));
          dig_nxt       = {dig_r[DigW-5:0], 4'd0};
          cnt_nxt       = cnt_r - 1'b1;
          if (cnt_r == CntW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dig_r      <= dig_nxt;
    bin_r      <= bin_nxt;
    neg_r      <= neg_nxt;
    step_r     <= step_nxt;
    cnt_r      <= cnt_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_char_r};
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

>>> tb/signed_integer_to_ascii_digits_tb.sv
// ----------------------------------------------------------------------------
// signed_integer_to_ascii_digits_tb: self-checking bench for the ASCII converter
// Feeds signed 32-bit values in decimal and hex mode. The run starts with a
// fixed table of corner cases, then random values follow. Every output beat is
// compared with characters worked out here. Both sides stall at random, with
// one long receiver hold-off and one pause that lets the output drain.
// ----------------------------------------------------------------------------
module signed_integer_to_ascii_digits_tb;

  localparam int VALUE_W         = 32;
  localparam int RANDOM_VALUES   = 310;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int QUIET_LIMIT     = 2000;
  localparam int TAIL_CYCLES     = 40;
  localparam int MAX_GAP         = 12;
  localparam int IDLE_PERCENT    = 35;
  localparam int unsigned RADIX_DEC = 10;
  localparam int unsigned RADIX_HEX = 16;
  localparam bit MODE_DEC = 1'b0;
  localparam bit MODE_HEX = 1'b1;

  // One expected output beat.
  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } char_beat_t;

  // A row of the corner-case table. An empty text means the row is checked
  // against the computed characters instead of typed-in ones.
  typedef struct {
    logic [VALUE_W-1:0] value;
    bit                 mode;
    string              text;
  } corner_row_t;

  localparam int CORNER_ROWS = 21;

  corner_row_t corner_rows [CORNER_ROWS] = '{
    '{32'h0000_0000, MODE_DEC, "0"},
    '{32'h0000_0000, MODE_HEX, "0"},
    '{32'h7FFF_FFFF, MODE_DEC, "2147483647"},
    '{32'h7FFF_FFFF, MODE_HEX, "7FFFFFFF"},
    '{32'h8000_0000, MODE_DEC, "-2147483648"},
    '{32'h8000_0000, MODE_HEX, "-80000000"},
    '{32'hFFFF_FFFF, MODE_DEC, "-1"},
    '{32'hFFFF_FFFF, MODE_HEX, "-1"},
    '{32'h0000_0009, MODE_DEC, "9"},
    '{32'h0000_000A, MODE_DEC, "10"},
    '{32'h0000_000F, MODE_HEX, "F"},
    '{32'h0000_0010, MODE_HEX, "10"},
    '{32'h1ABC_DEF0, MODE_HEX, "1ABCDEF0"},
    '{32'h0000_FACE, MODE_HEX, "FACE"},
    '{32'h8000_0001, MODE_HEX, "-7FFFFFFF"},
    '{32'h8000_0001, MODE_DEC, "-2147483647"},
    '{32'd1000000000, MODE_DEC, ""},
    '{32'hEDCB_5433, MODE_HEX, ""},
    '{32'h0BAD_F00D, MODE_DEC, ""},
    '{32'hC0FF_EE00, MODE_HEX, ""},
    '{32'hF8A4_32EB, MODE_DEC, ""}
  };

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [VALUE_W-1:0] in_tdata;   // [31:0] value
  logic               in_tuser;   // [0] mode
  logic               out_tvalid;
  logic               out_tready;
  logic [7:0]         out_tdata;  // [6:0] ascii_char
  logic               out_tlast;

  char_beat_t pending_chars [$];

  int  mismatch_count;
  int  chars_checked;
  int  values_sent;
  int  hex_values;
  int  negative_values;
  int  quiet_cycles;
  bit  steady;
  bit  hold_off_request;

  signed_integer_to_ascii_digits uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Works out the text of one value and queues its characters. The magnitude
  // of a negative value is taken as unsigned, so the most negative value
  // comes out as 2^31.
  function automatic void predict_text(input logic [VALUE_W-1:0] value, input bit mode);
    logic [VALUE_W-1:0] mag;
    logic [3:0]         d;
    logic [6:0]         digs [$];
    int unsigned        radix;
    mag   = value[VALUE_W-1] ? (~value + 1'b1) : value;
    radix = mode ? RADIX_HEX : RADIX_DEC;
    do begin
      d = 4'(mag % radix);
      digs.push_front((d < siad_pkg::DIGIT_TEN)
                      ? siad_pkg::CH_ZERO + 7'(d)
                      : siad_pkg::CH_UPPER_A + 7'(d - siad_pkg::DIGIT_TEN));
      mag = mag / radix;
    end while (mag != 0);
    if (value[VALUE_W-1]) begin
      pending_chars.push_back('{ch: siad_pkg::CH_MINUS, last: 1'b0});
    end
    foreach (digs[i]) begin
      pending_chars.push_back('{ch: digs[i], last: (i == digs.size() - 1)});
    end
  endfunction

  // Offers one value after a random gap and waits for the beat to be taken.
  // Acceptance is judged from values seen at the falling edge, which hold
  // through the next rising edge.
  task automatic offer_value(input logic [VALUE_W-1:0] value, input bit mode,
                             input string text);
    int gap;
    bit taken;
    gap = 0;
    while (!steady && gap < MAX_GAP && $urandom_range(99, 0) < IDLE_PERCENT) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom();
      in_tuser  <= 1'($urandom_range(1, 0));
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= mode;
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
    if (text.len() == 0) begin
      predict_text(value, mode);
    end else begin
      for (int k = 0; k < text.len(); k++) begin
        pending_chars.push_back('{ch: 7'(text[k]), last: (k == text.len() - 1)});
      end
    end
    values_sent++;
    if (mode) hex_values++;
    if (value[VALUE_W-1]) negative_values++;
  endtask

  // Receiver: random stalls, none during the steady stretch, and one long
  // hold-off on request so the block backs up into its input.
  initial begin : receiver
    int held;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_tready <= 1'b0;
        for (held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge clk);
      end
      out_tready <= steady || ($urandom_range(99, 0) >= IDLE_PERCENT);
    end
  end

  // Output checker. Beats are judged at the falling edge, where the values
  // that the next rising edge will take are already stable.
  always @(negedge clk) begin
    char_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected beat, actual char %h last %b", $time,
                 out_tdata[6:0], out_tlast);
        mismatch_count++;
      end else begin
        want = pending_chars.pop_front();
        if (out_tdata[6:0] !== want.ch) begin
          $display("%0t: ascii_char mismatch, expected %h actual %h", $time,
                   want.ch, out_tdata[6:0]);
          mismatch_count++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last mismatch, expected %b actual %b", $time,
                   want.last, out_tlast);
          mismatch_count++;
        end
        chars_checked++;
      end
    end
  end

  // Watchdog: ends the run if no beat moves on either side for too long.
  always @(negedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("signed_integer_to_ascii_digits_tb NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    logic [VALUE_W-1:0] value;
    logic [VALUE_W-1:0] step;
    bit                 mode;
    rst_n            = 1'b0;
    in_tvalid        = 1'b0;
    in_tdata         = '0;
    in_tuser         = 1'b0;
    steady           = 1'b0;
    hold_off_request = 1'b0;
    mismatch_count   = 0;
    chars_checked    = 0;
    values_sent      = 0;
    hex_values       = 0;
    negative_values  = 0;
    quiet_cycles     = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (corner_rows[r]) begin
      offer_value(corner_rows[r].value, corner_rows[r].mode, corner_rows[r].text);
    end

    for (int i = 0; i < RANDOM_VALUES; i++) begin
      if (i == 40) steady = 1'b1;
      if (i == 110) steady = 1'b0;
      if (i == 180) hold_off_request = 1'b1;
      // Let the output run dry once before going on.
      if (i == 250) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_chars.size() != 0) @(posedge clk);
      end
      mode = 1'($urandom_range(1, 0));
      case ($urandom_range(6, 0)) inside
        0, 1: value = $urandom();
        2: value = $urandom_range(20, 0);
        3: value = 32'd0 - $urandom_range(20, 1);
        4: begin
          value = $urandom() >> $urandom_range(31, 0);
          if ($urandom_range(1, 0)) value = -value;
        end
        5: begin
          // Near a power of the radix, where the digit count changes.
          step = 32'd1;
          if (mode) begin
            step = step << (4 * $urandom_range(7, 0));
          end else begin
            repeat ($urandom_range(9, 0)) step = step * RADIX_DEC;
          end
          value = step + $urandom_range(2, 0) - 1;
          if ($urandom_range(1, 0)) value = -value;
        end
        default: begin
          value = $urandom_range(1, 0) ? 32'h8000_0000 + $urandom_range(2, 0)
                                       : 32'h7FFF_FFFF - $urandom_range(2, 0);
        end
      endcase
      offer_value(value, mode, "");
    end
    in_tvalid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Converted %0d values (%0d hex, %0d negative) and checked %0d characters,",
             values_sent, hex_values, negative_values, chars_checked);
    $display("through random stalls, a long output hold-off and a drain pause.");
    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("signed_integer_to_ascii_digits_tb OK");
    end else begin
      $display("signed_integer_to_ascii_digits_tb NOT OK");
    end
    $finish;
  end

endmodule
